@@ hdl/banded_fan_drive_controller_assert.svh @@
// assertion macros for the banded fan drive controller
// used by the top level; compiled out when SYNTH is defined
`ifndef BANDED_FAN_DRIVE_CONTROLLER_ASSERT_SVH
`define BANDED_FAN_DRIVE_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

// checked only while out of reset
`define BFDC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bfdc assertion failed");

// checked at every edge, reset included
`define BFDC_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("bfdc assertion failed");

`else

`define BFDC_ASSERT(name, clk, rst_n, prop)
`define BFDC_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

@@ hdl/bfdc_pkg.sv @@
// shared types and constants for the banded fan drive controller
// no dependencies; imported by bfdc_core and the top level
`timescale 1ns / 1ps

package bfdc_pkg;

    localparam int TEMP_W     = 9;
    localparam int BOUNDARY_W = 7;
    localparam int CODE_W     = 12;
    localparam int JUMP_W     = 8;
    localparam int STEP_W     = 5;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 1;

    localparam int BFDC_BOUNDARY_MAX   = 99;
    localparam int BFDC_BOUNDARY_START = 75;

    // event kinds
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP_POLL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOUR  = 3'd5;

    // register reset values
    localparam logic [JUMP_W-1:0] RST_JUMP_LIMIT  = 8'd10;
    localparam logic [STEP_W-1:0] RST_BAND_STEP   = 5'd5;
    localparam logic [CODE_W-1:0] RST_LEVEL_ONE   = 12'd868;
    localparam logic [CODE_W-1:0] RST_LEVEL_TWO   = 12'd992;
    localparam logic [CODE_W-1:0] RST_LEVEL_THREE = 12'd1117;
    localparam logic [CODE_W-1:0] RST_LEVEL_FOUR  = 12'd1242;

    typedef struct packed {
        logic [JUMP_W-1:0] jump_limit;
        logic [STEP_W-1:0] band_step;
        logic [CODE_W-1:0] level_one;
        logic [CODE_W-1:0] level_two;
        logic [CODE_W-1:0] level_three;
        logic [CODE_W-1:0] level_four;
    } t_cfg;

    typedef struct packed {
        logic                     valid;
        logic [CMD_W-1:0]         cmd;
        logic signed [TEMP_W-1:0] temperature;
        logic                     button_level;
    } t_event;

    typedef struct packed {
        logic [CODE_W-1:0]        fan_code;
        logic [BOUNDARY_W-1:0]    fan_boundary;
        logic signed [TEMP_W-1:0] filtered_temperature;
        logic                     glitch_held;
    } t_result;

endpackage

@@ hdl/bfdc_core.sv @@
// event state and per-event update: glitch hold, band pick, up debouncer, down lockout
// depends on bfdc_pkg
`timescale 1ns / 1ps

module bfdc_core import bfdc_pkg::*; #(
    parameter int BOUNDARY_MAX   = BFDC_BOUNDARY_MAX,
    parameter int BOUNDARY_START = BFDC_BOUNDARY_START
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_event  i_event,
    output t_result o_result
);

    localparam logic [BOUNDARY_W-1:0] B_MAX   = BOUNDARY_MAX[BOUNDARY_W-1:0];
    localparam logic [BOUNDARY_W-1:0] B_START = BOUNDARY_START[BOUNDARY_W-1:0];
    localparam int CMP_W = TEMP_W + 2;
    localparam int DIFF_W = TEMP_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAYBE_PRESSED,
        ST_PRESSED,
        ST_MAYBE_RELEASED
    } t_phase;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [TEMP_W-1:0] a,
        input logic signed [TEMP_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic signed [TEMP_W-1:0] r_cur, r_prior, r_prior2;
    logic signed [TEMP_W-1:0] n_cur, n_prior, n_prior2;
    logic                     r_hist_valid, r_stable, r_down_en;
    logic                     n_hist_valid, n_stable, n_down_en;
    logic [BOUNDARY_W-1:0]    r_boundary, n_boundary;
    logic [CODE_W-1:0]        r_drive, n_drive;
    t_phase                   r_phase, n_phase;

    logic signed [TEMP_W-1:0] prior_base, prior2_base;
    logic [DIFF_W-1:0]        d_prior, d_prior2, jump_ext;
    logic                     hold;
    logic signed [CMP_W-1:0]  t_cmp, th_one, th_two, th_three;
    logic [CODE_W-1:0]        code_pick;
    logic [BOUNDARY_W-1:0]    up_boundary;

    // glitch hold on the shifted history
    always_comb begin
        if (!r_hist_valid) begin
            prior_base  = i_event.temperature;
            prior2_base = i_event.temperature;
        end else if (r_stable) begin
            prior_base  = r_cur;
            prior2_base = r_prior;
        end else begin
            prior_base  = r_prior;
            prior2_base = r_prior2;
        end
        d_prior  = abs_diff(i_event.temperature, prior_base);
        d_prior2 = abs_diff(i_event.temperature, prior2_base);
        jump_ext = DIFF_W'(i_cfg.jump_limit);
        hold     = r_stable && (d_prior > jump_ext) && (d_prior2 > jump_ext);
    end

    // band pick on the value that becomes current
    always_comb begin
        t_cmp    = CMP_W'(hold ? prior_base : i_event.temperature);
        th_one   = $signed(CMP_W'(r_boundary) + CMP_W'(i_cfg.band_step));
        th_two   = $signed(CMP_W'(r_boundary) + CMP_W'({i_cfg.band_step, 1'b0}));
        th_three = $signed(CMP_W'(r_boundary) + CMP_W'({i_cfg.band_step, 1'b0})
                   + CMP_W'(i_cfg.band_step));
        if (t_cmp < $signed(CMP_W'(r_boundary))) begin
            code_pick = '0;
        end else if (t_cmp < th_one) begin
            code_pick = i_cfg.level_one;
        end else if (t_cmp < th_two) begin
            code_pick = i_cfg.level_two;
        end else if (t_cmp < th_three) begin
            code_pick = i_cfg.level_three;
        end else begin
            code_pick = i_cfg.level_four;
        end
    end

    always_comb begin
        n_cur        = r_cur;
        n_prior      = r_prior;
        n_prior2     = r_prior2;
        n_hist_valid = r_hist_valid;
        n_stable     = r_stable;
        n_down_en    = r_down_en;
        n_boundary   = r_boundary;
        n_drive      = r_drive;
        n_phase      = r_phase;
        up_boundary  = r_boundary;

        if (i_event.valid) begin
            case (i_event.cmd)
                CMD_SAMPLE: begin
                    n_hist_valid = 1'b1;
                    n_prior      = prior_base;
                    n_prior2     = hold ? prior_base : prior2_base;
                    n_cur        = hold ? prior_base : i_event.temperature;
                    n_stable     = !hold;
                    n_drive      = code_pick;
                end
                CMD_UP_POLL: begin
                    unique case (r_phase)
                        ST_IDLE: begin
                            n_phase = i_event.button_level ? ST_MAYBE_PRESSED : ST_IDLE;
                        end
                        ST_MAYBE_PRESSED: begin
                            if (i_event.button_level) begin
                                n_phase = ST_PRESSED;
                                if (r_boundary < B_MAX) begin
                                    up_boundary = r_boundary + 1'b1;
                                end
                            end else begin
                                n_phase = ST_IDLE;
                            end
                        end
                        ST_PRESSED: begin
                            n_phase = i_event.button_level ? ST_PRESSED : ST_MAYBE_RELEASED;
                        end
                        default: begin
                            n_phase = i_event.button_level ? ST_PRESSED : ST_IDLE;
                        end
                    endcase
                    // a start value above the cap is pulled down on any poll
                    n_boundary = (up_boundary > B_MAX) ? B_MAX : up_boundary;
                end
                CMD_DOWN: begin
                    if (r_down_en) begin
                        if (r_boundary != '0) begin
                            n_boundary = r_boundary - 1'b1;
                        end
                        n_down_en = 1'b0;
                    end
                end
                default: begin
                    n_down_en = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_result.fan_code             = n_drive;
        o_result.fan_boundary         = n_boundary;
        o_result.filtered_temperature = n_cur;
        o_result.glitch_held          = (i_event.cmd == CMD_SAMPLE) && hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_prior      <= '0;
            r_prior2     <= '0;
            r_hist_valid <= 1'b0;
            r_stable     <= 1'b1;
            r_down_en    <= 1'b1;
            r_boundary   <= B_START;
            r_drive      <= '0;
            r_phase      <= ST_IDLE;
        end else begin
            r_cur        <= n_cur;
            r_prior      <= n_prior;
            r_prior2     <= n_prior2;
            r_hist_valid <= n_hist_valid;
            r_stable     <= n_stable;
            r_down_en    <= n_down_en;
            r_boundary   <= n_boundary;
            r_drive      <= n_drive;
            r_phase      <= n_phase;
        end
    end

endmodule

@@ hdl/banded_fan_drive_controller.sv @@
// banded fan drive controller
// Events arrive on the s_axis channel: tuser carries the event kind (sample, up-button
// poll tick, down press, lockout release), tdata the temperature and button level.
// Every event gives exactly one result beat on m_axis: fan drive code, boundary,
// filtered temperature in tdata, and the glitch-held flag in tuser.
// The input register loads at the accepting edge and the result register when that
// beat advances, which waits while the result register holds an untaken beat.
// Throughput is one event per cycle while results are taken; the state update for an
// event finishes in the same cycle it reads the state, so the next event follows directly.
// When the receiver stalls, the result register holds its beat and one more event
// may wait in the input register before s_axis_tready drops.
// Synchronous active-low reset empties both registers, loads the register defaults,
// sets the boundary to its start value and clears the temperature history.
// Configuration writes on i_cfg_* take effect at once; write only while idle.
// depends on bfdc_pkg, bfdc_core and banded_fan_drive_controller_assert.svh
`timescale 1ns / 1ps
`include "banded_fan_drive_controller_assert.svh"

module banded_fan_drive_controller import bfdc_pkg::*; #(
    parameter int BOUNDARY_MAX   = BFDC_BOUNDARY_MAX,
    parameter int BOUNDARY_START = BFDC_BOUNDARY_START
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [8:0] temperature, [9] button_level, [15:10] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [11:0] fan_code, [18:12] fan_boundary, [27:19] filtered_temperature, [31:28] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] glitch_held
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int BOUND_LIMIT = (BOUNDARY_START > BOUNDARY_MAX) ? BOUNDARY_START
                                                                  : BOUNDARY_MAX;
    localparam int RES_W = CODE_W + BOUNDARY_W + TEMP_W;

    t_cfg    r_cfg;
    t_event  r_in, core_event;
    t_result core_result, r_out;
    logic    r_out_valid;
    logic    advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump_limit  <= RST_JUMP_LIMIT;
            r_cfg.band_step   <= RST_BAND_STEP;
            r_cfg.level_one   <= RST_LEVEL_ONE;
            r_cfg.level_two   <= RST_LEVEL_TWO;
            r_cfg.level_three <= RST_LEVEL_THREE;
            r_cfg.level_four  <= RST_LEVEL_FOUR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_JUMP_LIMIT:  r_cfg.jump_limit  <= i_cfg_data[JUMP_W-1:0];
                CFG_BAND_STEP:   r_cfg.band_step   <= i_cfg_data[STEP_W-1:0];
                CFG_LEVEL_ONE:   r_cfg.level_one   <= i_cfg_data[CODE_W-1:0];
                CFG_LEVEL_TWO:   r_cfg.level_two   <= i_cfg_data[CODE_W-1:0];
                CFG_LEVEL_THREE: r_cfg.level_three <= i_cfg_data[CODE_W-1:0];
                CFG_LEVEL_FOUR:  r_cfg.level_four  <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // the input beat moves on when the result register is free or being drained
    assign advance       = r_in.valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in.valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in.valid        <= s_axis_tvalid;
            r_in.cmd          <= s_axis_tuser[CMD_W-1:0];
            r_in.temperature  <= s_axis_tdata[TEMP_W-1:0];
            r_in.button_level <= s_axis_tdata[TEMP_W];
        end
    end

    always_comb begin
        core_event       = r_in;
        core_event.valid = advance;
    end

    bfdc_core #(
        .BOUNDARY_MAX   (BOUNDARY_MAX),
        .BOUNDARY_START (BOUNDARY_START)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_event  (core_event),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), r_out.filtered_temperature,
                            r_out.fan_boundary, r_out.fan_code};
    assign m_axis_tuser  = r_out.glitch_held;

    // a waiting input beat is never dropped
    `BFDC_ASSERT(a_in_kept, i_clk, i_rst_n, r_in.valid && !advance |=> r_in.valid)

    // every processed beat shows up as a result
    `BFDC_ASSERT(a_out_filled, i_clk, i_rst_n, advance |=> m_axis_tvalid)

    // boundary stays within its cap or the start value
    `BFDC_ASSERT(a_bound_cap, i_clk, i_rst_n,
        m_axis_tvalid |-> r_out.fan_boundary <= BOUND_LIMIT[BOUNDARY_W-1:0])

    // nothing leaves in the cycle after reset
    `BFDC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

@@ bench/banded_fan_drive_controller_test.sv @@
// self-checking bench for banded_fan_drive_controller: directed events, then random traffic
// under three register settings, every result beat checked against a typed value or an in-bench predictor
// depends on bfdc_pkg and the controller rtl only
`timescale 1ns / 1ps

module banded_fan_drive_controller_test import bfdc_pkg::*;;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;

    typedef enum logic [1:0] {
        DB_IDLE, DB_MAYBE_PRESSED, DB_PRESSED, DB_MAYBE_RELEASED
    } t_debounce;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        int               temp;
        bit               btn;
        bit               typed;
        int               code;
        int               bnd;
        int               ftemp;
        bit               held;
    } t_event_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [8:0] temperature, [9] button_level, [15:10] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] cmd
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [11:0] fan_code, [18:12] fan_boundary, [27:19] filtered_temperature, [31:28] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] glitch_held
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // predictor state
    t_cfg      fan_cfg;
    int        p_cur, p_prior, p_prior2;
    bit        p_hist_valid, p_stable, p_down_en;
    int        p_boundary;
    t_debounce p_debounce;
    logic [CODE_W-1:0] p_drive;

    t_result fan_results_q[$];
    int      err_count = 0;
    int      cycle_count = 0;
    int      src_idle_pct = 36;
    int      sink_idle_pct = 63;

    t_event_row event_rows [23] = '{
        '{CMD_RELEASE,    0, 0, 1,   0, 75,    0, 0},
        '{CMD_DOWN,       0, 0, 1,   0, 74,    0, 0},
        '{CMD_DOWN,       0, 1, 1,   0, 74,    0, 0},  // locked out
        '{CMD_RELEASE,    0, 0, 1,   0, 74,    0, 0},
        '{CMD_SAMPLE,    80, 0, 1, 992, 74,   80, 0},  // first sample fills history
        '{CMD_SAMPLE,   255, 0, 1, 992, 74,   80, 1},  // jump, held once
        '{CMD_SAMPLE,  -256, 0, 1,   0, 74, -256, 0},  // second jump passes
        '{CMD_SAMPLE,     0, 1, 0,   0,  0,    0, 0},
        '{CMD_SAMPLE,  -250, 0, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,   17, 1, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,    0, 1, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,    0, 1, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,    0, 0, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,    0, 1, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,    0, 0, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,    0, 0, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,    0, 1, 0,   0,  0,    0, 0},
        '{CMD_UP_POLL,   -1, 0, 0,   0,  0,    0, 0},
        '{CMD_SAMPLE,    79, 0, 0,   0,  0,    0, 0},
        '{CMD_SAMPLE,    95, 0, 0,   0,  0,    0, 0},
        '{CMD_SAMPLE,    90, 1, 0,   0,  0,    0, 0},
        '{CMD_DOWN,      -1, 1, 0,   0,  0,    0, 0},
        '{CMD_RELEASE,  255, 1, 0,   0,  0,    0, 0}
    };

    banded_fan_drive_controller uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void clear_predictor();
        fan_cfg.jump_limit  = RST_JUMP_LIMIT;
        fan_cfg.band_step   = RST_BAND_STEP;
        fan_cfg.level_one   = RST_LEVEL_ONE;
        fan_cfg.level_two   = RST_LEVEL_TWO;
        fan_cfg.level_three = RST_LEVEL_THREE;
        fan_cfg.level_four  = RST_LEVEL_FOUR;
        p_cur = 0;
        p_prior = 0;
        p_prior2 = 0;
        p_hist_valid = 0;
        p_stable = 1;
        p_down_en = 1;
        p_boundary = BFDC_BOUNDARY_START;
        p_debounce = DB_IDLE;
        p_drive = '0;
    endfunction

    // advance the predicted controller by one event and return its result beat
    function automatic t_result fan_predict(logic [CMD_W-1:0] cmd, int temp, bit btn);
        t_result r;
        bit held;
        int s;
        held = 0;
        case (cmd)
            CMD_SAMPLE: begin
                if (p_stable && p_hist_valid) begin
                    p_prior2 = p_prior;
                    p_prior = p_cur;
                end
                p_cur = temp;
                if (!p_hist_valid) begin
                    p_prior = temp;
                    p_prior2 = temp;
                    p_hist_valid = 1;
                end
                if (p_stable && (temp > p_prior ? temp - p_prior : p_prior - temp)
                        > int'(fan_cfg.jump_limit)
                    && (temp > p_prior2 ? temp - p_prior2 : p_prior2 - temp)
                        > int'(fan_cfg.jump_limit)) begin
                    p_cur = p_prior;
                    p_prior2 = p_prior;
                    p_stable = 0;
                    held = 1;
                end else if (!p_stable) begin
                    p_stable = 1;
                end
                s = int'(fan_cfg.band_step);
                if (p_cur < p_boundary)
                    p_drive = '0;
                else if (p_cur < p_boundary + s)
                    p_drive = fan_cfg.level_one;
                else if (p_cur < p_boundary + 2 * s)
                    p_drive = fan_cfg.level_two;
                else if (p_cur < p_boundary + 3 * s)
                    p_drive = fan_cfg.level_three;
                else
                    p_drive = fan_cfg.level_four;
            end
            CMD_UP_POLL: begin
                case (p_debounce)
                    DB_IDLE: p_debounce = btn ? DB_MAYBE_PRESSED : DB_IDLE;
                    DB_MAYBE_PRESSED: begin
                        if (btn) begin
                            p_debounce = DB_PRESSED;
                            if (p_boundary < BFDC_BOUNDARY_MAX)
                                p_boundary++;
                        end else begin
                            p_debounce = DB_IDLE;
                        end
                    end
                    DB_PRESSED: p_debounce = btn ? DB_PRESSED : DB_MAYBE_RELEASED;
                    default: p_debounce = btn ? DB_PRESSED : DB_IDLE;
                endcase
            end
            CMD_DOWN: begin
                if (p_down_en) begin
                    if (p_boundary > 0)
                        p_boundary--;
                    p_down_en = 0;
                end
            end
            default: p_down_en = 1;
        endcase
        r.fan_code = p_drive;
        r.fan_boundary = BOUNDARY_W'(p_boundary);
        r.filtered_temperature = TEMP_W'(p_cur);
        r.glitch_held = held;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (fan_results_q.size() == 0) begin
                report_mismatch("unexpected result beat", int'(m_axis_tdata), 0);
            end else begin
                want = fan_results_q.pop_front();
                if (m_axis_tdata[11:0] !== want.fan_code)
                    report_mismatch("fan_code", m_axis_tdata[11:0], want.fan_code);
                if (m_axis_tdata[18:12] !== want.fan_boundary)
                    report_mismatch("fan_boundary", m_axis_tdata[18:12], want.fan_boundary);
                if (m_axis_tdata[27:19] !== want.filtered_temperature)
                    report_mismatch("filtered_temperature", $signed(m_axis_tdata[27:19]),
                                    want.filtered_temperature);
                if (m_axis_tdata[31:28] !== 4'b0)
                    report_mismatch("tdata pad", m_axis_tdata[31:28], 0);
                if (m_axis_tuser[0] !== want.glitch_held)
                    report_mismatch("glitch_held", m_axis_tuser[0], want.glitch_held);
            end
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_event(logic [CMD_W-1:0] cmd, int temp, bit btn,
                              bit typed, t_result typed_res);
        t_result pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'b0, btn, TEMP_W'(temp)};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = fan_predict(cmd, temp, btn);
        fan_results_q.push_back(typed ? typed_res : pred);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (fan_results_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // leaves the write enable high; program_regs lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_JUMP_LIMIT:  fan_cfg.jump_limit = data[JUMP_W-1:0];
            CFG_BAND_STEP:   fan_cfg.band_step = data[STEP_W-1:0];
            CFG_LEVEL_ONE:   fan_cfg.level_one = data;
            CFG_LEVEL_TWO:   fan_cfg.level_two = data;
            CFG_LEVEL_THREE: fan_cfg.level_three = data;
            CFG_LEVEL_FOUR:  fan_cfg.level_four = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // upper bits above the jump limit and band step widths carry junk, indexes past the last are junk writes
    task automatic program_regs(int jump, int step, int c1, int c2, int c3, int c4);
        write_reg(CFG_JUMP_LIMIT, CFG_DATA_W'(jump) | (CFG_DATA_W'($urandom_range(15)) << 8));
        write_reg(CFG_BAND_STEP, CFG_DATA_W'(step) | (CFG_DATA_W'($urandom_range(127)) << 5));
        write_reg(CFG_LEVEL_ONE, CFG_DATA_W'(c1));
        write_reg(CFG_LEVEL_TWO, CFG_DATA_W'(c2));
        write_reg(CFG_LEVEL_THREE, CFG_DATA_W'(c3));
        write_reg(CFG_LEVEL_FOUR, CFG_DATA_W'(c4));
        write_reg(CFG_IDX_W'(6), CFG_DATA_W'($urandom));
        write_reg(CFG_IDX_W'(7), 12'hFFF);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int pick_temp();
        int r, span, t;
        r = $urandom_range(99);
        span = (fan_cfg.jump_limit > 40 ? 40 : int'(fan_cfg.jump_limit)) + 3;
        if (r < 55)
            t = p_cur + int'($urandom_range(2 * span)) - span;
        else if (r < 85)
            t = p_boundary + int'($urandom_range(4 * int'(fan_cfg.band_step) + 6)) - 3;
        else
            t = int'($urandom_range(511)) - 256;
        if (t > 255) t = 255;
        if (t < -256) t = -256;
        return t;
    endfunction

    // early items push the boundary up, the middle stretch pulls it down, the rest mixes
    task automatic send_random(int n);
        int r, temp;
        logic [CMD_W-1:0] cmd;
        bit btn;
        t_result none;
        none = '0;
        r = $urandom_range(99);
        temp = int'($urandom_range(511)) - 256;
        btn = $urandom_range(1);
        if (n < 400)
            cmd = r < 55 ? CMD_UP_POLL : r < 95 ? CMD_SAMPLE : r < 97 ? CMD_DOWN : CMD_RELEASE;
        else if (n < 900)
            cmd = r < 40 ? CMD_DOWN : r < 75 ? CMD_RELEASE : r < 95 ? CMD_SAMPLE : CMD_UP_POLL;
        else
            cmd = r < 40 ? CMD_SAMPLE : r < 70 ? CMD_UP_POLL : r < 85 ? CMD_DOWN : CMD_RELEASE;
        if (cmd == CMD_SAMPLE)
            temp = pick_temp();
        send_event(cmd, temp, btn, 0, none);
    endtask

    initial begin
        t_result typed_res;
        clear_predictor();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (event_rows[k]) begin
            typed_res.fan_code = CODE_W'(event_rows[k].code);
            typed_res.fan_boundary = BOUNDARY_W'(event_rows[k].bnd);
            typed_res.filtered_temperature = TEMP_W'(event_rows[k].ftemp);
            typed_res.glitch_held = event_rows[k].held;
            send_event(event_rows[k].cmd, event_rows[k].temp, event_rows[k].btn,
                       event_rows[k].typed, typed_res);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                case (n / PHASE_ITEMS)
                    0: begin
                        // zero band step: everything at or over the boundary gets level four
                        program_regs(0, 0, 0, 4095, 1, 4094);
                        src_idle_pct = 36;
                        sink_idle_pct = 63;
                    end
                    1: begin
                        program_regs(255, 31, 4095, 0, 4094, 1);
                        src_idle_pct = 63;
                        sink_idle_pct = 36;
                    end
                    default: begin
                        program_regs($urandom_range(1, 30), $urandom_range(1, 31),
                                     $urandom_range(4095), $urandom_range(4095),
                                     $urandom_range(4095), $urandom_range(4095));
                        src_idle_pct = 0;
                        sink_idle_pct = 0;
                    end
                endcase
            end
            send_random(n);
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
